// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock, quiet in reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication, quiet in reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ===== hw/rtl/bpa_pkg.sv =====
// types, constants and address helpers of the bitmap page allocator
package bpa_pkg;
   localparam int MAX_PAGES_DEF = 8192;
   localparam int MAX_RUN_DEF   = 64;
   localparam int WORD_W        = 32;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_BAD      = 2'd1;
   localparam logic [1:0] ST_NO_VIRT  = 2'd2;
   localparam logic [1:0] ST_NO_PHYS  = 2'd3;

   localparam logic [1:0] CSR_VIRT_BASE  = 2'd0;
   localparam logic [1:0] CSR_PHYS_BASE  = 2'd1;
   localparam logic [1:0] CSR_POOL_PAGES = 2'd2;

   typedef struct packed {
      logic       pool_select;
      logic [6:0] page_count;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] virt_addr;
      logic [31:0] phys_addr;
      logic [31:0] table_entry_addr;
      logic [31:0] dir_entry_addr;
      logic [31:0] entry_value;
      logic        last;
   } rsp_type;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_VRD, S_VSCAN, S_VMRD, S_VMARK,
      S_PRD, S_PSCAN, S_PMARK, S_ADDR, S_OUT
   } state_type;

   function automatic logic [31:0] pte_addr(input logic [31:0] v);
      pte_addr = 32'hFFC0_0000 + {10'd0, v[31:22], 12'd0} + {20'd0, v[21:12], 2'd0};
   endfunction

   function automatic logic [31:0] pde_addr(input logic [31:0] v);
      pde_addr = 32'hFFFF_F000 + {20'd0, v[31:22], 2'd0};
   endfunction
endpackage

// ===== hw/rtl/bpa_bitmap.sv =====
// word-wide bitmap memory with registered read and one write port
module bpa_bitmap import bpa_pkg::*; #(
   parameter int MAX_PAGES = MAX_PAGES_DEF,
   localparam int DEPTH = (MAX_PAGES + WORD_W - 1) / WORD_W,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic [AW-1:0]     rd_addr,
   output logic [WORD_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [WORD_W-1:0] wr_data
);
   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

// ===== hw/rtl/bitmap_page_allocator.sv =====
// top level of the bitmap page allocator
//
//  channel | direction | handshake      | payload
//  req_    | in        | valid / stall  | req_type (pool, page count)
//  rsp_    | out       | valid / stall  | rsp_type (status, addresses, last)
//  csr_    | in        | valid / ready  | index, 32-bit data
//
// after reset a clearing pass zeroes both bitmaps word by word before any
// request transfer is taken
// one request at a time; a rejected request answers the cycle after its transfer
// virtual scan: a read state per 32-bit word plus a test state per bit tested;
// marking takes a read state per word plus a mark state per page
// each page then takes a physical scan from word 0 (a read state per word and
// a test state per bit to the free frame) then mark, address and output states
// rsp_stall holds the result register; nothing advances until it is taken
module bitmap_page_allocator import bpa_pkg::*; #(
   parameter int MAX_PAGES = MAX_PAGES_DEF,
   parameter int MAX_RUN   = MAX_RUN_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);
   localparam int DEPTH = (MAX_PAGES + WORD_W - 1) / WORD_W;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int IW    = $clog2(MAX_PAGES + 1);
   localparam int RW    = $clog2(MAX_RUN + 1);

   // configuration
   logic [31:0] virt_base_ff, phys_base_ff;
   logic [13:0] pool_pages_ff;
   logic [IW-1:0] nbits;

   always_ff @(posedge clock) begin
      if (reset) begin
         virt_base_ff  <= 32'hC010_0000;
         phys_base_ff  <= 32'h0020_0000;
         pool_pages_ff <= 14'd3840;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_VIRT_BASE:  virt_base_ff  <= csr_data;
            CSR_PHYS_BASE:  phys_base_ff  <= csr_data;
            CSR_POOL_PAGES: pool_pages_ff <= csr_data[13:0];
            default: ;
         endcase
      end
   end
   assign csr_ready = 1'b1;

   // bits in use: rounded down to a multiple of eight, limited to the bitmap size
   always_comb begin
      logic [31:0] n;
      n = {18'd0, pool_pages_ff[13:3], 3'd0};
      if (n > 32'(MAX_PAGES)) n = 32'(MAX_PAGES);
      nbits = n[IW-1:0];
   end

   // sequencer state
   state_type state_ff, state_in;
   logic [AW-1:0]     waddr_ff, waddr_in;   // word being scanned / marked
   logic [4:0]        bit_ff, bit_in;       // bit within the word
   logic [IW-1:0]     idx_ff, idx_in;       // absolute bit index
   logic [RW-1:0]     run_ff, run_in;       // free-run length of the virtual scan
   logic [IW-1:0]     vstart_ff, vstart_in;
   logic [RW-1:0]     mark_ff, mark_in;     // pages left to mark
   logic [6:0]        cnt_ff, cnt_in;
   logic [6:0]        done_ff, done_in;
   logic [IW-1:0]     pidx_ff, pidx_in;
   logic [WORD_W-1:0] word_ff, word_in;
   logic              load_ff, load_in;     // fresh bitmap word on the read port
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   // bitmap ports
   logic [AW-1:0]     v_rd, p_rd, v_wa, p_wa;
   logic [WORD_W-1:0] v_q, p_q, v_wd, p_wd;
   logic              v_we, p_we;

   bpa_bitmap #(.MAX_PAGES(MAX_PAGES)) u_virt (
      .clock(clock), .rd_addr(v_rd), .rd_data(v_q),
      .wr_en(v_we), .wr_addr(v_wa), .wr_data(v_wd));
   bpa_bitmap #(.MAX_PAGES(MAX_PAGES)) u_phys (
      .clock(clock), .rd_addr(p_rd), .rd_data(p_q),
      .wr_en(p_we), .wr_addr(p_wa), .wr_data(p_wd));

   logic              req_xfer, rsp_xfer, bad_req, word_end, last_bit;
   logic              cur_bit, v_hit;
   logic [WORD_W-1:0] word_cur;
   logic [IW-1:0]     vstart_calc;
   logic [31:0]       vpage, vaddr, paddr;
   assign req_xfer = req_valid && !req_stall;
   assign rsp_xfer = rsp_valid_ff && !rsp_stall;
   assign bad_req  = req_data.pool_select || req_data.page_count == 7'd0 ||
                     32'(req_data.page_count) > 32'(MAX_RUN);
   assign word_end = bit_ff == 5'd31;
   assign last_bit = idx_ff + IW'(1) >= nbits;

   // word under test: straight from the read port after a read state
   assign word_cur = !load_ff ? word_ff : (state_ff == S_PSCAN) ? p_q : v_q;
   assign cur_bit  = word_cur[bit_ff];
   assign v_hit    = !cur_bit && run_ff + RW'(1) == RW'(cnt_ff);
   assign vstart_calc = idx_ff + IW'(1) - IW'(cnt_ff);

   // address unit: a separate shift-add for each address
   assign vpage = 32'(vstart_ff) + 32'(done_ff);
   assign vaddr = virt_base_ff + (vpage << 12);
   assign paddr = phys_base_ff + (32'(pidx_ff) << 12);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: if (waddr_ff == AW'(DEPTH - 1)) state_in = S_IDLE;
         S_IDLE:  if (req_xfer) state_in = bad_req ? S_OUT : S_VRD;
         S_VRD:   state_in = (idx_ff >= nbits) ? S_OUT : S_VSCAN;
         S_VSCAN: begin
            if (v_hit) state_in = S_VMRD;
            else if (last_bit) state_in = S_OUT;
            else if (word_end) state_in = S_VRD;
         end
         S_VMRD:  state_in = S_VMARK;
         S_VMARK: begin
            if (mark_ff == RW'(1)) state_in = S_PRD;
            else if (word_end) state_in = S_VMRD;
         end
         S_PRD:   state_in = (idx_ff >= nbits) ? S_OUT : S_PSCAN;
         S_PSCAN: begin
            if (!cur_bit) state_in = S_PMARK;
            else if (last_bit) state_in = S_OUT;
            else if (word_end) state_in = S_PRD;
         end
         S_PMARK: state_in = S_ADDR;
         S_ADDR:  state_in = S_OUT;
         S_OUT: if (rsp_xfer) begin
            if (rsp_ff.last) state_in = S_IDLE;
            else state_in = S_PRD;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and bitmap control
   always_comb begin
      waddr_in = waddr_ff; bit_in = bit_ff; idx_in = idx_ff; run_in = run_ff;
      vstart_in = vstart_ff; mark_in = mark_ff; cnt_in = cnt_ff; done_in = done_ff;
      pidx_in = pidx_ff; word_in = word_ff; rsp_valid_in = rsp_valid_ff; rsp_in = rsp_ff;
      load_in = 1'b0;
      v_rd = waddr_ff; p_rd = waddr_ff; v_wa = waddr_ff; p_wa = waddr_ff;
      v_wd = '0; p_wd = '0; v_we = 1'b0; p_we = 1'b0;
      if (rsp_xfer) rsp_valid_in = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            v_we = 1'b1; p_we = 1'b1;
            waddr_in = waddr_ff + AW'(1);
         end
         S_IDLE: begin
            waddr_in = '0; bit_in = '0; idx_in = '0; run_in = '0; done_in = '0;
            cnt_in = req_data.page_count;
            if (req_xfer && bad_req) begin
               rsp_in = '0; rsp_in.status = ST_BAD; rsp_in.last = 1'b1; rsp_valid_in = 1'b1;
            end
         end
         S_VRD: begin
            // word arrives on the read port next cycle
            load_in = 1'b1;
            if (idx_ff >= nbits) begin
               rsp_in = '0; rsp_in.status = ST_NO_VIRT; rsp_in.last = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         S_VSCAN: begin
            word_in = word_cur;
            if (cur_bit) run_in = '0;
            else run_in = run_ff + RW'(1);
            if (v_hit) begin
               // go back to the run start and mark it word by word
               vstart_in = vstart_calc;
               idx_in = vstart_calc;
               waddr_in = AW'(vstart_calc >> 5);
               bit_in = 5'(vstart_calc);
               mark_in = RW'(cnt_ff);
            end else if (last_bit) begin
               rsp_in = '0; rsp_in.status = ST_NO_VIRT; rsp_in.last = 1'b1;
               rsp_valid_in = 1'b1;
            end else begin
               idx_in = idx_ff + IW'(1);
               bit_in = bit_ff + 5'd1;
               if (word_end) waddr_in = waddr_ff + AW'(1);
            end
         end
         S_VMRD: load_in = 1'b1;
         S_VMARK: begin
            // read-modify-write of the held word, one bit per cycle
            word_in = word_cur | (WORD_W'(1) << bit_ff);
            v_we = 1'b1; v_wd = word_in;
            mark_in = mark_ff - RW'(1);
            bit_in = bit_ff + 5'd1;
            idx_in = idx_ff + IW'(1);
            if (mark_ff == RW'(1)) begin
               waddr_in = '0; bit_in = '0; idx_in = '0;
            end else if (word_end) begin
               waddr_in = waddr_ff + AW'(1);
            end
         end
         S_PRD: begin
            load_in = 1'b1;
            if (idx_ff >= nbits) begin
               rsp_in = '0; rsp_in.status = ST_NO_PHYS; rsp_in.last = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         S_PSCAN: begin
            word_in = word_cur;
            if (!cur_bit) begin
               pidx_in = idx_ff;
            end else if (last_bit) begin
               rsp_in = '0; rsp_in.status = ST_NO_PHYS; rsp_in.last = 1'b1;
               rsp_valid_in = 1'b1;
            end else begin
               idx_in = idx_ff + IW'(1);
               bit_in = bit_ff + 5'd1;
               if (word_end) waddr_in = waddr_ff + AW'(1);
            end
         end
         S_PMARK: begin
            p_we = 1'b1; p_wd = word_ff | (WORD_W'(1) << bit_ff);
         end
         S_ADDR: begin
            rsp_in.status = ST_OK;
            rsp_in.virt_addr = vaddr;
            rsp_in.phys_addr = paddr;
            rsp_in.table_entry_addr = pte_addr(vaddr);
            rsp_in.dir_entry_addr = pde_addr(vaddr);
            rsp_in.entry_value = paddr | 32'd7;
            rsp_in.last = (done_ff + 7'd1 == cnt_ff);
            rsp_valid_in = 1'b1;
            done_in = done_ff + 7'd1;
         end
         S_OUT: begin
            waddr_in = '0; bit_in = '0; idx_in = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         waddr_ff <= '0;
         rsp_valid_ff <= 1'b0;
         load_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         waddr_ff <= waddr_in;
         rsp_valid_ff <= rsp_valid_in;
         load_ff <= load_in;
      end
      bit_ff <= bit_in; idx_ff <= idx_in; run_ff <= run_in; vstart_ff <= vstart_in;
      mark_ff <= mark_in; cnt_ff <= cnt_in; done_ff <= done_in; pidx_ff <= pidx_in;
      rsp_ff <= rsp_in;
      word_ff <= word_in;
   end

   assign req_stall = state_ff != S_IDLE || rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`include "assert_macros.svh"
   `ASSERT_IMPL(a_idle_only, clock, reset, req_xfer, state_ff == S_IDLE)
   `ASSERT_NEXT(a_hold, clock, reset, rsp_valid_ff && rsp_stall, rsp_valid_ff && $stable(rsp_ff))
   `ASSERT_IMPL(a_no_write_idle, clock, reset, state_ff == S_IDLE, !v_we && !p_we)
endmodule

// ===== tb/sv/bitmap_page_allocator_checker.sv =====
// result predictor and scoreboard for the bitmap page allocator channels
module bitmap_page_allocator_checker import bpa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  rsp_type     rsp_data,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data,
   output int          pending,
   output int          fail_count,
   output int          checked
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PAGES = MAX_PAGES_DEF;

   logic [31:0] virt_base;
   logic [31:0] phys_base;
   logic [13:0] pool_pages;
   bit          virt_map [PAGES];
   bit          phys_map [PAGES];
   rsp_type     page_q [$];

   task automatic report(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      fail_count++;
   endtask

   // lowest start of a clear run of len bits within the bits in use, -1 if none
   function automatic int lowest_run(input bit in_phys, input int len);
      int n;
      int run;
      bit used;
      n = pool_pages & 14'h3FF8;
      if (n > PAGES) n = PAGES;
      run = 0;
      for (int i = 0; i < n; i++) begin
         used = in_phys ? phys_map[i] : virt_map[i];
         if (used) begin
            run = 0;
         end else begin
            run++;
            if (run == len) return i + 1 - len;
         end
      end
      return -1;
   endfunction

   function automatic rsp_type status_only(input logic [1:0] st);
      rsp_type r;
      r = '0;
      r.status = st;
      r.last = 1'b1;
      return r;
   endfunction

   task automatic predict_pages(input req_type r);
      int cnt;
      int vstart;
      int pidx;
      rsp_type e;
      logic [31:0] v;
      logic [31:0] p;
      cnt = r.page_count;
      if (r.pool_select || cnt == 0 || cnt > MAX_RUN_DEF) begin
         page_q.push_back(status_only(ST_BAD));
         return;
      end
      vstart = lowest_run(1'b0, cnt);
      if (vstart < 0) begin
         page_q.push_back(status_only(ST_NO_VIRT));
         return;
      end
      for (int j = 0; j < cnt; j++) virt_map[vstart + j] = 1'b1;
      for (int j = 0; j < cnt; j++) begin
         pidx = lowest_run(1'b1, 1);
         if (pidx < 0) begin
            page_q.push_back(status_only(ST_NO_PHYS));
            return;
         end
         phys_map[pidx] = 1'b1;
         v = virt_base + (32'(vstart + j) << 12);
         p = phys_base + (32'(pidx) << 12);
         e = '0;
         e.status = ST_OK;
         e.virt_addr = v;
         e.phys_addr = p;
         e.table_entry_addr = 32'hFFC0_0000 + ((v & 32'hFFC0_0000) >> 10)
                              + (((v & 32'h003F_F000) >> 12) << 2);
         e.dir_entry_addr = 32'hFFFF_F000 + (((v & 32'hFFC0_0000) >> 22) << 2);
         e.entry_value = p | 32'h7;
         e.last = (j + 1 == cnt);
         page_q.push_back(e);
      end
   endtask

   task automatic compare_page(input rsp_type got);
      rsp_type e;
      if (page_q.size() == 0) begin
         report($sformatf("unexpected result transfer %h", got));
         return;
      end
      e = page_q.pop_front();
      checked++;
      if (got.status !== e.status)
         report($sformatf("status %0d, want %0d", got.status, e.status));
      if (got.virt_addr !== e.virt_addr)
         report($sformatf("virt_addr %h, want %h", got.virt_addr, e.virt_addr));
      if (got.phys_addr !== e.phys_addr)
         report($sformatf("phys_addr %h, want %h", got.phys_addr, e.phys_addr));
      if (got.table_entry_addr !== e.table_entry_addr)
         report($sformatf("table_entry_addr %h, want %h",
                          got.table_entry_addr, e.table_entry_addr));
      if (got.dir_entry_addr !== e.dir_entry_addr)
         report($sformatf("dir_entry_addr %h, want %h",
                          got.dir_entry_addr, e.dir_entry_addr));
      if (got.entry_value !== e.entry_value)
         report($sformatf("entry_value %h, want %h", got.entry_value, e.entry_value));
      if (got.last !== e.last)
         report($sformatf("last %0d, want %0d", got.last, e.last));
   endtask

   initial begin
      fail_count = 0;
      checked = 0;
   end

   assign pending = page_q.size();

   always @(posedge clock) begin
      if (reset) begin
         virt_base <= 32'hC010_0000;
         phys_base <= 32'h0020_0000;
         pool_pages <= 14'd3840;
         for (int i = 0; i < PAGES; i++) begin
            virt_map[i] = 1'b0;
            phys_map[i] = 1'b0;
         end
         page_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_VIRT_BASE:  virt_base <= csr_data;
               CSR_PHYS_BASE:  phys_base <= csr_data;
               CSR_POOL_PAGES: pool_pages <= csr_data[13:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) predict_pages(req_data);
         if (rsp_valid && !rsp_stall) compare_page(rsp_data);
      end
   end
endmodule

// ===== tb/sv/bitmap_page_allocator_tb.sv =====
// stimulus, clocking and verdict for the bitmap page allocator testbench
module bitmap_page_allocator_tb import bpa_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   // generous: every request taking 64 pages, each page a full physical scan,
   // under the slowest stall pattern, with room to spare
   localparam int CYCLE_LIMIT = 600000000;
   localparam int HOLD_CYCLES = 3000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_VIRT_BASE;
   logic [31:0] csr_data = '0;

   int pending;
   int fail_count;
   int checked;
   int cycle_count = 0;
   int stall_mode = 0;
   bit hold_req = 1'b0;
   bit hold_done = 1'b0;
   int req_sent = 0;

   always #1 clock = ~clock;

   bitmap_page_allocator u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   bitmap_page_allocator_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .pending(pending), .fail_count(fail_count), .checked(checked)
   );

   // watchdog: a hung handshake ends the run as a failure
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // receiver: stalls on its own pattern, with one long hold-off on request
   initial begin
      int phase;
      phase = 0;
      forever begin
         @(negedge clock);
         if (hold_req && !hold_done) begin
            // hold the result channel so the block backs up into its input
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end
         phase++;
         case (stall_mode)
            0: rsp_stall = 1'b0;
            1: rsp_stall = ($urandom_range(0, 3) == 0);
            2: rsp_stall = 1'($urandom_range(0, 1));
            default: rsp_stall = ((phase % 11) < 4);
         endcase
      end
   end

   // one request transfer, then an optional gap with valid low
   task automatic send_req(input logic pool, input logic [6:0] count, input int gap);
      @(negedge clock);
      req_valid = 1'b1;
      req_data.pool_select = pool;
      req_data.page_count = count;
      do @(posedge clock); while (req_stall);
      req_sent++;
      if (gap > 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [31:0] value);
      @(negedge clock);
      req_valid = 1'b0;
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // every page result taken, then a margin before touching registers
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (50) @(negedge clock);
   endtask

   task automatic set_pool(input logic [31:0] vbase, input logic [31:0] pbase,
                           input logic [31:0] pages);
      drain();
      write_csr(CSR_VIRT_BASE, vbase);
      write_csr(CSR_PHYS_BASE, pbase);
      write_csr(CSR_POOL_PAGES, pages);
   endtask

   // mostly small kernel requests, some long runs, the rest rejected noise
   task automatic random_reqs(input int n);
      int burst;
      int pick;
      logic [6:0] count;
      logic pool;
      burst = $urandom_range(1, 8);
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 99);
         pool = 1'b0;
         if (pick < 70) count = 7'($urandom_range(1, 8));
         else if (pick < 80) count = 7'($urandom_range(9, 64));
         else if (pick < 88) begin
            pool = 1'b1;
            count = 7'($urandom_range(0, 127));
         end else if (pick < 93) count = 7'd0;
         else count = 7'($urandom_range(65, 127));
         burst--;
         if (burst == 0) begin
            burst = $urandom_range(1, 8);
            send_req(pool, count, $urandom_range(1, 12));
         end else begin
            send_req(pool, count, 0);
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty pool at the top of the address space: the valid request misses, the rest are rejected
      set_pool(32'hFFFF_F000, 32'hFFFF_F000, 32'd7);
      send_req(1'b0, 7'd1, 0);
      send_req(1'b1, 7'd5, 0);
      send_req(1'b1, 7'd0, 0);
      send_req(1'b0, 7'd0, 0);
      send_req(1'b0, 7'd65, 0);
      send_req(1'b0, 7'd127, 2);

      // sixteen-page pool whose addresses wrap past the 4 GiB boundary
      set_pool(32'hFFFF_F000, 32'hFFFF_F000, 32'd23);
      send_req(1'b0, 7'd1, 0);
      send_req(1'b0, 7'd2, 0);
      send_req(1'b0, 7'd8, 0);
      send_req(1'b0, 7'd6, 0);
      send_req(1'b0, 7'd5, 0);
      send_req(1'b0, 7'd1, 3);

      // oversized register value clamps the bitmap length; longest runs
      stall_mode = 1;
      set_pool(32'h0000_0000, 32'h0000_0000, 32'd16383);
      send_req(1'b0, 7'd64, 0);
      send_req(1'b0, 7'd64, 0);
      send_req(1'b0, 7'd1, 0);
      send_req(1'b1, 7'd127, 0);

      // back to the power-on layout
      stall_mode = 2;
      set_pool(32'hC010_0000, 32'h0020_0000, 32'd3840);
      random_reqs(50);

      stall_mode = 3;
      set_pool($urandom_range(0, 32'hFFFF_F000), $urandom_range(0, 32'hFFFF_F000),
               32'({$urandom_range(0, 32'h3FFFF), 14'd0}) | $urandom_range(1000, 8192));
      random_reqs(25);
      drain();               // sender waits for the last page result
      random_reqs(25);

      // long receiver hold-off while requests keep coming
      stall_mode = 0;
      set_pool($urandom_range(0, 32'hFFFF_F000), $urandom_range(0, 32'hFFFF_F000),
               32'd8192);
      hold_req = 1'b1;
      random_reqs(50);

      stall_mode = 1;
      set_pool(32'hFFFF_F000, 32'h0000_0000, $urandom_range(2000, 8192));
      random_reqs(64);

      drain();
      repeat (200) @(negedge clock);
      $display("%0d request transfers sent, %0d page results checked", req_sent, checked);
      $display("covered rejects, exhausted and wrapping pools, long runs and stalls");
      if (fail_count == 0 && pending == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/bpa_pkg.sv
hw/rtl/bpa_bitmap.sv
hw/rtl/bitmap_page_allocator.sv
tb/sv/bitmap_page_allocator_checker.sv
tb/sv/bitmap_page_allocator_tb.sv
